[design/ged_pkg.sv]
// Shared types and constants of the GPIO controller with edge detection.
// Holds the word map, action codes, lane control and lane state structs.
// No dependencies; every other file of the block imports it.
package ged_pkg;

   localparam int NUM_PINS       = 60;
   localparam int PIN_W          = 60;
   localparam int PAD_W          = 64;
   localparam int BANK_W         = 32;
   localparam int FSEL_W         = 3;
   localparam int FSEL_WORDS     = 6;
   localparam int PINS_PER_FSEL  = 10;
   localparam int FSEL_SLOTS     = FSEL_WORDS * PINS_PER_FSEL;
   localparam int FSEL_IDX_W     = $clog2(FSEL_WORDS);
   localparam int PULL_W         = 2;
   localparam int WORD_W         = 6;
   localparam int ACT_W          = 2;

   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

   localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;
   localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
   localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

   localparam logic [WORD_W-1:0] WORD_SET0  = 6'd7;
   localparam logic [WORD_W-1:0] WORD_SET1  = 6'd8;
   localparam logic [WORD_W-1:0] WORD_CLR0  = 6'd10;
   localparam logic [WORD_W-1:0] WORD_CLR1  = 6'd11;
   localparam logic [WORD_W-1:0] WORD_LEV0  = 6'd13;
   localparam logic [WORD_W-1:0] WORD_LEV1  = 6'd14;
   localparam logic [WORD_W-1:0] WORD_EVT0  = 6'd16;
   localparam logic [WORD_W-1:0] WORD_EVT1  = 6'd17;
   localparam logic [WORD_W-1:0] WORD_RISE0 = 6'd19;
   localparam logic [WORD_W-1:0] WORD_RISE1 = 6'd20;
   localparam logic [WORD_W-1:0] WORD_FALL0 = 6'd22;
   localparam logic [WORD_W-1:0] WORD_FALL1 = 6'd23;
   localparam logic [WORD_W-1:0] WORD_HIGH0 = 6'd25;
   localparam logic [WORD_W-1:0] WORD_HIGH1 = 6'd26;
   localparam logic [WORD_W-1:0] WORD_LOW0  = 6'd28;
   localparam logic [WORD_W-1:0] WORD_LOW1  = 6'd29;
   localparam logic [WORD_W-1:0] WORD_PUD   = 6'd37;
   localparam logic [WORD_W-1:0] WORD_CLK0  = 6'd38;
   localparam logic [WORD_W-1:0] WORD_CLK1  = 6'd39;

   // Write strobes decoded from one bus write; bank pairs are [hi, lo].
   typedef struct packed {
      logic [FSEL_WORDS-1:0] fsel_we;
      logic [1:0]            set_we;
      logic [1:0]            clr_we;
      logic [1:0]            evclr_we;
      logic [1:0]            rise_we;
      logic [1:0]            fall_we;
      logic [1:0]            high_we;
      logic [1:0]            low_we;
      logic [1:0]            clk_we;
      logic                  pud_we;
   } bus_dec_type;

   // Per-pin view of the current transfer.
   typedef struct packed {
      logic              fsel_we;
      logic [FSEL_W-1:0] fsel_data;
      logic              set_we;
      logic              clr_we;
      logic              evclr_we;
      logic              rise_we;
      logic              fall_we;
      logic              high_we;
      logic              low_we;
      logic              pull_we;
      logic              data_bit;
      logic [PULL_W-1:0] pull_code;
      logic              level;
   } lane_ctl_type;

   typedef struct packed {
      logic [FSEL_W-1:0] fsel;
      logic [PULL_W-1:0] pull;
      logic              latch;
      logic              rise;
      logic              fall;
      logic              high;
      logic              low;
      logic              evt;
   } lane_state_type;

   typedef struct packed {
      logic [BANK_W-1:0] read_data;
      logic [PIN_W-1:0]  out_levels;
      logic [PIN_W-1:0]  out_enable;
      logic [PIN_W-1:0]  pull_up;
      logic [PIN_W-1:0]  pull_down;
      logic              irq;
   } rsp_type;

endpackage

[design/ged_req_if.sv]
// Request and response channel interfaces of the GPIO controller.
// Each carries valid, ready and the payload fields; widths come from ged_pkg.
interface ged_req_if import ged_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [WORD_W-1:0]   word_index;
   logic [BANK_W-1:0]   write_data;
   logic [PIN_W-1:0]    pin_levels;

   modport source (output valid, output action, output word_index,
                   output write_data, output pin_levels, input ready);
   modport sink   (input valid, input action, input word_index,
                   input write_data, input pin_levels, output ready);
endinterface

interface ged_rsp_if import ged_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BANK_W-1:0]   read_data;
   logic [PIN_W-1:0]    out_levels;
   logic [PIN_W-1:0]    out_enable;
   logic [PIN_W-1:0]    pull_up;
   logic [PIN_W-1:0]    pull_down;
   logic                irq;

   modport source (output valid, output read_data, output out_levels,
                   output out_enable, output pull_up, output pull_down,
                   output irq, input ready);
   modport sink   (input valid, input read_data, input out_levels,
                   input out_enable, input pull_up, input pull_down,
                   input irq, output ready);
endinterface

[design/ged_lane.sv]
// One pin lane: function select, pull code, output latch, detect enables,
// event status and previous level of a single pin. Depends on ged_pkg.
module ged_lane import ged_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  lane_ctl_type   ctl,
   output lane_state_type cur_state,
   output lane_state_type nxt_state
);

   lane_state_type state_ff, state_in;
   logic           prev_ff, prev_in;
   logic           ev;

   always_comb begin
      state_in = state_ff;
      if (ctl.fsel_we) begin
         state_in.fsel = ctl.fsel_data;
      end
      if (ctl.set_we && ctl.data_bit) begin
         state_in.latch = 1'b1;
      end
      if (ctl.clr_we && ctl.data_bit) begin
         state_in.latch = 1'b0;
      end
      if (ctl.rise_we) begin
         state_in.rise = ctl.data_bit;
      end
      if (ctl.fall_we) begin
         state_in.fall = ctl.data_bit;
      end
      if (ctl.high_we) begin
         state_in.high = ctl.data_bit;
      end
      if (ctl.low_we) begin
         state_in.low = ctl.data_bit;
      end
      if (ctl.pull_we && ctl.data_bit) begin
         state_in.pull = ctl.pull_code;
      end
      // Detection uses the enables after this transfer's write.
      ev = (!prev_ff && ctl.level && state_in.rise)
         | (prev_ff && !ctl.level && state_in.fall)
         | (ctl.level && state_in.high)
         | (!ctl.level && state_in.low);
      // A new event wins over a clear in the same transfer.
      state_in.evt = (state_ff.evt && !(ctl.evclr_we && ctl.data_bit)) || ev;
      prev_in = ctl.level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         prev_ff  <= 1'b0;
      end else if (en) begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
      end
   end

   assign cur_state = state_ff;
   assign nxt_state = state_in;

endmodule

[design/ged_merge.sv]
// Merge stage: gathers the pin lanes into the read word, the output vectors
// and the interrupt line. Depends on ged_pkg.
module ged_merge import ged_pkg::*; (
   input  lane_state_type    cur_state [NUM_PINS],
   input  lane_state_type    nxt_state [NUM_PINS],
   input  logic              rd,
   input  logic [WORD_W-1:0] word_index,
   input  logic [PIN_W-1:0]  pin_levels,
   input  logic [PULL_W-1:0] pull_control,
   output rsp_type           rsp
);

   logic [FSEL_W-1:0] fsel_all [FSEL_SLOTS];
   logic [BANK_W-1:0] fsel_word [FSEL_WORDS];
   logic [PAD_W-1:0]  evt_v, rise_v, fall_v, high_v, low_v, lev_v;
   logic [PAD_W-1:0]  bank_v;
   logic              bank_hi, bank_hit;
   logic [BANK_W-1:0] rdata;

   always_comb begin
      evt_v  = '0;
      rise_v = '0;
      fall_v = '0;
      high_v = '0;
      low_v  = '0;
      lev_v  = '0;
      for (int i = 0; i < FSEL_SLOTS; i++) begin
         fsel_all[i] = '0;
      end
      for (int i = 0; i < NUM_PINS; i++) begin
         fsel_all[i] = cur_state[i].fsel;
         evt_v[i]    = cur_state[i].evt;
         rise_v[i]   = cur_state[i].rise;
         fall_v[i]   = cur_state[i].fall;
         high_v[i]   = cur_state[i].high;
         low_v[i]    = cur_state[i].low;
         lev_v[i]    = pin_levels[i];
      end
      for (int w = 0; w < FSEL_WORDS; w++) begin
         fsel_word[w] = '0;
         for (int k = 0; k < PINS_PER_FSEL; k++) begin
            fsel_word[w][FSEL_W*k +: FSEL_W] = fsel_all[w*PINS_PER_FSEL + k];
         end
      end
   end

   always_comb begin
      bank_v   = '0;
      bank_hi  = 1'b0;
      bank_hit = 1'b1;
      rdata    = '0;
      unique case (word_index)
         WORD_LEV0:  bank_v = lev_v;
         WORD_LEV1:  begin bank_v = lev_v;  bank_hi = 1'b1; end
         WORD_EVT0:  bank_v = evt_v;
         WORD_EVT1:  begin bank_v = evt_v;  bank_hi = 1'b1; end
         WORD_RISE0: bank_v = rise_v;
         WORD_RISE1: begin bank_v = rise_v; bank_hi = 1'b1; end
         WORD_FALL0: bank_v = fall_v;
         WORD_FALL1: begin bank_v = fall_v; bank_hi = 1'b1; end
         WORD_HIGH0: bank_v = high_v;
         WORD_HIGH1: begin bank_v = high_v; bank_hi = 1'b1; end
         WORD_LOW0:  bank_v = low_v;
         WORD_LOW1:  begin bank_v = low_v;  bank_hi = 1'b1; end
         default:    bank_hit = 1'b0;
      endcase
      if (word_index < WORD_W'(FSEL_WORDS)) begin
         rdata = fsel_word[word_index[FSEL_IDX_W-1:0]];
      end else if (word_index == WORD_PUD) begin
         rdata = BANK_W'(pull_control);
      end else if (bank_hit) begin
         rdata = bank_hi ? bank_v[PAD_W-1:BANK_W] : bank_v[BANK_W-1:0];
      end
   end

   always_comb begin
      rsp            = '0;
      rsp.read_data  = rd ? rdata : '0;
      for (int i = 0; i < NUM_PINS; i++) begin
         rsp.out_levels[i] = nxt_state[i].latch;
         rsp.out_enable[i] = (nxt_state[i].fsel == FSEL_OUTPUT);
         rsp.pull_up[i]    = (nxt_state[i].pull == PULL_UP);
         rsp.pull_down[i]  = (nxt_state[i].pull == PULL_DOWN);
         rsp.irq           = rsp.irq | nxt_state[i].evt;
      end
   end

endmodule

[design/gpio_controller_edge_detect_core.sv]
// GPIO controller with edge and level detection, top level.
// Uses ged_pkg, the ged_req_if / ged_rsp_if channels, ged_lane and ged_merge.
//
// Usage:
//   req_bus carries one transfer per cycle while req_bus.ready is high: an
//   action (sample only, bus read or bus write), a register word index,
//   write data and the sampled level of every pin. rsp_bus returns exactly
//   one result per request: the read word (zero unless a read of a readable
//   word; it shows the stored state before the request), and the output
//   latch, enables, pull-up/pull-down masks and irq, showing the state after.
//   Throughput: one request per cycle while req_bus.ready is high; all pins
//   are handled at once by one lane per pin, and the merge stage forms the
//   read word and irq.
//   Stall: a two-entry output buffer (result register plus skid register)
//   holds results while rsp_bus.ready is low; req_bus.ready drops only once
//   both entries are full and comes back the cycle after one is taken.
//   Reset: synchronous, active high. Clears all pin state (inputs, no pull,
//   latch, enables and events zero), the pull control word and the output
//   buffer. No clearing pass; requests are taken right after reset.
module gpio_controller_edge_detect_core import ged_pkg::*; (
   input logic       clock,
   input logic       reset,
   ged_req_if.sink   req_bus,
   ged_rsp_if.source rsp_bus
);

   logic              accept, is_read, is_write;
   bus_dec_type       dec;
   logic [PULL_W-1:0] pull_control_ff, pull_control_in;
   lane_state_type    cur_state [NUM_PINS];
   lane_state_type    nxt_state [NUM_PINS];
   rsp_type           rsp_new;
   rsp_type           out_ff, out_in, skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_read       = (req_bus.action == ACT_READ);
   assign is_write      = (req_bus.action == ACT_WRITE);

   always_comb begin
      dec = '0;
      for (int w = 0; w < FSEL_WORDS; w++) begin
         dec.fsel_we[w] = is_write && (req_bus.word_index == WORD_W'(w));
      end
      if (is_write) begin
         unique case (req_bus.word_index)
            WORD_SET0:  dec.set_we[0]   = 1'b1;
            WORD_SET1:  dec.set_we[1]   = 1'b1;
            WORD_CLR0:  dec.clr_we[0]   = 1'b1;
            WORD_CLR1:  dec.clr_we[1]   = 1'b1;
            WORD_EVT0:  dec.evclr_we[0] = 1'b1;
            WORD_EVT1:  dec.evclr_we[1] = 1'b1;
            WORD_RISE0: dec.rise_we[0]  = 1'b1;
            WORD_RISE1: dec.rise_we[1]  = 1'b1;
            WORD_FALL0: dec.fall_we[0]  = 1'b1;
            WORD_FALL1: dec.fall_we[1]  = 1'b1;
            WORD_HIGH0: dec.high_we[0]  = 1'b1;
            WORD_HIGH1: dec.high_we[1]  = 1'b1;
            WORD_LOW0:  dec.low_we[0]   = 1'b1;
            WORD_LOW1:  dec.low_we[1]   = 1'b1;
            WORD_CLK0:  dec.clk_we[0]   = 1'b1;
            WORD_CLK1:  dec.clk_we[1]   = 1'b1;
            WORD_PUD:   dec.pud_we      = 1'b1;
            default:    dec.pud_we      = 1'b0;
         endcase
      end
   end

   assign pull_control_in = dec.pud_we ? req_bus.write_data[PULL_W-1:0] : pull_control_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_control_ff <= '0;
      end else if (accept) begin
         pull_control_ff <= pull_control_in;
      end
   end

   for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
      lane_ctl_type ctl;
      always_comb begin
         ctl.fsel_we   = dec.fsel_we[i / PINS_PER_FSEL];
         ctl.fsel_data = req_bus.write_data[FSEL_W*(i % PINS_PER_FSEL) +: FSEL_W];
         ctl.set_we    = dec.set_we[i / BANK_W];
         ctl.clr_we    = dec.clr_we[i / BANK_W];
         ctl.evclr_we  = dec.evclr_we[i / BANK_W];
         ctl.rise_we   = dec.rise_we[i / BANK_W];
         ctl.fall_we   = dec.fall_we[i / BANK_W];
         ctl.high_we   = dec.high_we[i / BANK_W];
         ctl.low_we    = dec.low_we[i / BANK_W];
         ctl.pull_we   = dec.clk_we[i / BANK_W];
         ctl.data_bit  = req_bus.write_data[i % BANK_W];
         ctl.pull_code = pull_control_ff;
         ctl.level     = req_bus.pin_levels[i];
      end

      ged_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .en        (accept),
         .ctl       (ctl),
         .cur_state (cur_state[i]),
         .nxt_state (nxt_state[i])
      );
   end

   ged_merge u_merge (
      .cur_state    (cur_state),
      .nxt_state    (nxt_state),
      .rd           (is_read),
      .word_index   (req_bus.word_index),
      .pin_levels   (req_bus.pin_levels),
      .pull_control (pull_control_ff),
      .rsp          (rsp_new)
   );

   // Output register with a skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in        = rsp_new;
            out_valid_in  = accept;
         end
      end else if (accept) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.read_data  = out_ff.read_data;
   assign rsp_bus.out_levels = out_ff.out_levels;
   assign rsp_bus.out_enable = out_ff.out_enable;
   assign rsp_bus.pull_up    = out_ff.pull_up;
   assign rsp_bus.pull_down  = out_ff.pull_down;
   assign rsp_bus.irq        = out_ff.irq;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted transfer left no result");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_read) |-> (rsp_new.read_data == '0))
      else $error("non-read transfer returned read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result changed while the receiver stalled");

endmodule
